>>> design/rrs_pkg.sv
// shared constants, types and codes of the round-robin scheduler
package rrs_pkg;

   // table size and stored time width
   localparam int MAX_JOBS   = 16;
   localparam int TIME_BITS  = 16;
   localparam int IDX_BITS   = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
   localparam int COUNT_BITS = $clog2(MAX_JOBS + 1);

   // fixed field widths
   localparam int SLICE_BITS = 16;
   localparam int CLOCK_BITS = 20;
   localparam int TOTAL_BITS = 24;
   localparam int ID_BITS    = 5;

   typedef logic [TIME_BITS-1:0]  time_type;
   typedef logic [IDX_BITS-1:0]   idx_type;
   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [MAX_JOBS-1:0]   mask_type;
   typedef logic [SLICE_BITS-1:0] slice_type;
   typedef logic [CLOCK_BITS-1:0] clock_type;
   typedef logic [TOTAL_BITS-1:0] total_type;
   typedef logic [ID_BITS-1:0]    id_type;

   // request kinds
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_RUN  = 1'b1;

   // result status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_FULL    = 2'd1;
   localparam logic [1:0] STATUS_NOTHING = 2'd2;

   // request payload
   typedef struct packed {
      logic        req_type;
      logic [15:0] job_burst;
   } req_item_type;

   // result payload
   typedef struct packed {
      logic        slice_valid;
      id_type      job_id;
      slice_type   slice_length;
      logic        job_done;
      clock_type   done_time;
      clock_type   wait_time;
      clock_type   clock_now;
      logic        all_finished;
      total_type   sum_wait;
      total_type   sum_done;
      logic [1:0]  status;
   } rsp_item_type;

   // outcome of the rotating priority search
   typedef struct packed {
      logic    found;
      idx_type idx;
   } pick_type;

endpackage

>>> design/rrs_ram.sv
// generic single-write, single-read synchronous ram with registered read data
module rrs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/rrs_pick.sv
// rotating priority search for the next pending job at or after the cursor
module rrs_pick (
   input  rrs_pkg::mask_type pending,
   input  rrs_pkg::idx_type  cursor,
   output rrs_pkg::pick_type pick
);

   logic [2*rrs_pkg::MAX_JOBS-1:0] doubled;
   rrs_pkg::mask_type              rotated;
   rrs_pkg::idx_type               pos;
   logic [rrs_pkg::IDX_BITS:0]     sum;

   // rotate so the cursor lands on bit zero
   assign doubled = {pending, pending} >> cursor;
   assign rotated = doubled[rrs_pkg::MAX_JOBS-1:0];

   // lowest set bit of the rotated mask
   always_comb begin
      pos = '0;
      for (int i = rrs_pkg::MAX_JOBS - 1; i >= 0; i--) begin
         if (rotated[i]) begin
            pos = rrs_pkg::idx_type'(i);
         end
      end
   end

   // undo the rotation, wrapping at the table size
   always_comb begin
      sum = {1'b0, cursor} + {1'b0, pos};
      if (sum >= (rrs_pkg::IDX_BITS+1)'(rrs_pkg::MAX_JOBS)) begin
         sum = sum - (rrs_pkg::IDX_BITS+1)'(rrs_pkg::MAX_JOBS);
      end
      pick.found = |pending;
      pick.idx   = sum[rrs_pkg::IDX_BITS-1:0];
   end

endmodule

>>> design/round_robin_scheduler_sim_top.sv
// top level of the round-robin time-slice scheduler
//
// Requests enter on req_item when start is high and busy is low. A load
// request appends a burst time to the job table; a run request grants one
// time slice to the next unfinished job after the one served last.
// Every request gives exactly one result on rsp_item, marked by rsp_valid
// for a single cycle; the receiver cannot stall, so results never wait.
// Sequence: a load, a refused load and a run with nothing pending show
// their result in the cycle after acceptance, and busy stays low. A granted
// run picks its job and reads the remaining-time and burst memories in the
// accept cycle, updates the remaining time and clock in ST_READ, and sums
// the totals in ST_FINISH, which registers its result; busy is high through
// ST_READ and ST_FINISH. Loads sustain one per cycle while no run is in
// flight; no new request is taken during a granted run, as busy covers the
// read-modify-write of the remaining-time memory and the totals update.
// The quantum register sits at byte address 0 of the APB port (reset 1, a
// value of 0 acts as 1); write it only while no request is in flight.
// Synchronous reset empties the table and clears the clock and totals; the
// memories need no clearing since only loaded entries are read.
module round_robin_scheduler_sim_top (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  start,
   output logic                  busy,
   input  rrs_pkg::req_item_type req_item,
   // result channel
   output logic                  rsp_valid,
   output rrs_pkg::rsp_item_type rsp_item,
   // configuration port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [2:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_READ   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   localparam logic [32:0] TIME_LIMIT = (33'd1 << rrs_pkg::TIME_BITS) - 33'd1;
   localparam logic [rrs_pkg::CLOCK_BITS:0] CLOCK_LIMIT =
      {1'b0, {rrs_pkg::CLOCK_BITS{1'b1}}};
   localparam logic [rrs_pkg::TOTAL_BITS:0] TOTAL_LIMIT =
      {1'b0, {rrs_pkg::TOTAL_BITS{1'b1}}};

   // control state
   logic [1:0]            state_ff, state_in;
   rrs_pkg::count_type    job_count_ff, job_count_in;
   rrs_pkg::count_type    fin_count_ff, fin_count_in;
   rrs_pkg::mask_type     flags_ff, flags_in;
   rrs_pkg::idx_type      cursor_ff, cursor_in;
   rrs_pkg::clock_type    clock_ff, clock_in;
   rrs_pkg::total_type    wait_total_ff, wait_total_in;
   rrs_pkg::total_type    done_total_ff, done_total_in;
   rrs_pkg::slice_type    quantum_ff, quantum_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // payload state
   rrs_pkg::idx_type      idx_ff, idx_in;
   rrs_pkg::slice_type    run_ff, run_in;
   logic                  done_ff, done_in;
   rrs_pkg::rsp_item_type rsp_item_ff, rsp_item_in;

   logic                  accept;
   logic                  is_run;
   logic                  full;
   logic                  load_ok;
   rrs_pkg::idx_type      slot;
   rrs_pkg::mask_type     loaded;
   rrs_pkg::mask_type     pending;
   rrs_pkg::pick_type     pick;
   logic [32:0]           burst_wide;
   rrs_pkg::time_type     burst_sat;
   rrs_pkg::time_type     burst_rd;
   rrs_pkg::time_type     rem_rd;
   rrs_pkg::time_type     rem_new;
   logic                  rem_wr_en;
   rrs_pkg::idx_type      rem_wr_addr;
   rrs_pkg::time_type     rem_wr_data;
   logic                  rd_en;
   rrs_pkg::slice_type    q_eff;
   rrs_pkg::slice_type    run_calc;
   logic [rrs_pkg::CLOCK_BITS:0] clock_sum;
   rrs_pkg::clock_type    wait_calc;
   logic [rrs_pkg::TOTAL_BITS:0] wait_sum;
   logic [rrs_pkg::TOTAL_BITS:0] done_sum;
   logic                  cfg_write;

   // handshake
   assign busy    = (state_ff != ST_IDLE);
   assign accept  = start & ~busy;
   assign is_run  = (req_item.req_type == rrs_pkg::REQ_RUN);
   assign full    = (job_count_ff == rrs_pkg::count_type'(rrs_pkg::MAX_JOBS));
   assign load_ok = accept & ~is_run & ~full;
   assign slot    = job_count_ff[rrs_pkg::IDX_BITS-1:0];

   // pending mask: loaded and not finished
   always_comb begin
      for (int i = 0; i < rrs_pkg::MAX_JOBS; i++) begin
         loaded[i] = (rrs_pkg::count_type'(i) < job_count_ff);
      end
   end
   assign pending = loaded & ~flags_ff;

   rrs_pick u_pick (
      .pending (pending),
      .cursor  (cursor_ff),
      .pick    (pick)
   );

   // burst saturated to the stored width
   assign burst_wide = {17'd0, req_item.job_burst};
   assign burst_sat  = (burst_wide > TIME_LIMIT) ? rrs_pkg::time_type'(TIME_LIMIT)
                                                 : rrs_pkg::time_type'(burst_wide);

   // memory ports
   assign rd_en       = accept & is_run & pick.found;
   assign rem_wr_en   = load_ok | (state_ff == ST_READ);
   assign rem_wr_addr = load_ok ? slot : idx_ff;
   assign rem_wr_data = load_ok ? burst_sat : rem_new;

   rrs_ram #(
      .WIDTH (rrs_pkg::TIME_BITS),
      .DEPTH (rrs_pkg::MAX_JOBS)
   ) u_burst_ram (
      .clock   (clock),
      .wr_en   (load_ok),
      .wr_addr (slot),
      .wr_data (burst_sat),
      .rd_en   (rd_en),
      .rd_addr (pick.idx),
      .rd_data (burst_rd)
   );

   rrs_ram #(
      .WIDTH (rrs_pkg::TIME_BITS),
      .DEPTH (rrs_pkg::MAX_JOBS)
   ) u_remaining_ram (
      .clock   (clock),
      .wr_en   (rem_wr_en),
      .wr_addr (rem_wr_addr),
      .wr_data (rem_wr_data),
      .rd_en   (rd_en),
      .rd_addr (pick.idx),
      .rd_data (rem_rd)
   );

   // slice length and new remaining time
   assign q_eff    = (quantum_ff == '0) ? rrs_pkg::slice_type'(1) : quantum_ff;
   assign run_calc = ({17'd0, rem_rd} <= {17'd0, q_eff}) ? rrs_pkg::slice_type'(rem_rd)
                                                         : q_eff;
   assign rem_new  = rem_rd - rrs_pkg::time_type'(run_calc);
   assign clock_sum = {1'b0, clock_ff} + (rrs_pkg::CLOCK_BITS+1)'(run_calc);

   // waiting time and running totals
   always_comb begin
      if ({13'd0, clock_ff} >= {1'b0, 32'(burst_rd)}) begin
         wait_calc = rrs_pkg::clock_type'({13'd0, clock_ff} - {1'b0, 32'(burst_rd)});
      end else begin
         wait_calc = '0;
      end
   end
   assign wait_sum = {1'b0, wait_total_ff} + (rrs_pkg::TOTAL_BITS+1)'(wait_calc);
   assign done_sum = {1'b0, done_total_ff} + (rrs_pkg::TOTAL_BITS+1)'(clock_ff);

   // sequencer and state update
   always_comb begin
      state_in      = state_ff;
      job_count_in  = job_count_ff;
      fin_count_in  = fin_count_ff;
      flags_in      = flags_ff;
      cursor_in     = cursor_ff;
      clock_in      = clock_ff;
      wait_total_in = wait_total_ff;
      done_total_in = done_total_ff;
      idx_in        = idx_ff;
      run_in        = run_ff;
      done_in       = done_ff;
      rsp_valid_in  = 1'b0;
      rsp_item_in   = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!is_run) begin
                  rsp_valid_in = 1'b1;
                  if (full) begin
                     rsp_item_in.status = rrs_pkg::STATUS_FULL;
                  end else begin
                     flags_in[slot]      = 1'b0;
                     job_count_in        = job_count_ff + 1'b1;
                     rsp_item_in.job_id  = rrs_pkg::id_type'(job_count_in);
                     rsp_item_in.status  = rrs_pkg::STATUS_OK;
                  end
               end else if (!pick.found) begin
                  rsp_valid_in       = 1'b1;
                  rsp_item_in.status = rrs_pkg::STATUS_NOTHING;
               end else begin
                  idx_in   = pick.idx;
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            run_in   = run_calc;
            done_in  = (rem_new == '0);
            clock_in = (clock_sum > CLOCK_LIMIT) ? rrs_pkg::clock_type'(CLOCK_LIMIT)
                                                 : rrs_pkg::clock_type'(clock_sum);
            if (idx_ff == rrs_pkg::idx_type'(rrs_pkg::MAX_JOBS - 1)) begin
               cursor_in = '0;
            end else begin
               cursor_in = idx_ff + 1'b1;
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            rsp_valid_in             = 1'b1;
            rsp_item_in.slice_valid  = 1'b1;
            rsp_item_in.job_id       =
               rrs_pkg::id_type'(rrs_pkg::count_type'(idx_ff) + 1'b1);
            rsp_item_in.slice_length = run_ff;
            rsp_item_in.status       = rrs_pkg::STATUS_OK;
            if (done_ff) begin
               flags_in[idx_ff]      = 1'b1;
               fin_count_in          = fin_count_ff + 1'b1;
               wait_total_in = (wait_sum > TOTAL_LIMIT) ? rrs_pkg::total_type'(TOTAL_LIMIT)
                                                        : rrs_pkg::total_type'(wait_sum);
               done_total_in = (done_sum > TOTAL_LIMIT) ? rrs_pkg::total_type'(TOTAL_LIMIT)
                                                        : rrs_pkg::total_type'(done_sum);
               rsp_item_in.job_done  = 1'b1;
               rsp_item_in.done_time = clock_ff;
               rsp_item_in.wait_time = wait_calc;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // fields common to every result
      rsp_item_in.clock_now    = clock_in;
      rsp_item_in.all_finished = (fin_count_in == job_count_in);
      rsp_item_in.sum_wait     = wait_total_in;
      rsp_item_in.sum_done     = done_total_in;
   end

   // configuration write and read back
   assign cfg_write  = psel & penable & pwrite & pready;
   assign quantum_in = (cfg_write && !paddr[2]) ? pwdata[15:0] : quantum_ff;
   assign prdata     = paddr[2] ? 32'd0 : {16'd0, quantum_ff};
   assign pready     = 1'b1;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         job_count_ff  <= '0;
         fin_count_ff  <= '0;
         flags_ff      <= '0;
         cursor_ff     <= '0;
         clock_ff      <= '0;
         wait_total_ff <= '0;
         done_total_ff <= '0;
         quantum_ff    <= rrs_pkg::slice_type'(1);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         job_count_ff  <= job_count_in;
         fin_count_ff  <= fin_count_in;
         flags_ff      <= flags_in;
         cursor_ff     <= cursor_in;
         clock_ff      <= clock_in;
         wait_total_ff <= wait_total_in;
         done_total_ff <= done_total_in;
         quantum_ff    <= quantum_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      run_ff      <= run_in;
      done_ff     <= done_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // a load request is answered in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (accept && !is_run) |=> rsp_valid)
      else $error("load request not answered in the next cycle");

   // a granted run walks read then finish
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |=> (state_ff == ST_FINISH))
      else $error("run sequence skipped its finish step");

   // finish flags agree with the finished count
   assert property (@(posedge clock) disable iff (reset)
      $countones(flags_ff) == 32'(fin_count_ff))
      else $error("finish flags disagree with finished count");

   // table never overfills and never finishes more than it holds
   assert property (@(posedge clock) disable iff (reset)
      (job_count_ff <= rrs_pkg::count_type'(rrs_pkg::MAX_JOBS))
      && (fin_count_ff <= job_count_ff))
      else $error("job or finished count out of range");

   // no result is issued from the read step of a granted run
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> !rsp_valid_in)
      else $error("result issued in the middle of a run");

endmodule

>>> bench/sched_bench_pkg.sv
// register map shared by the scheduler bench modules
package sched_bench_pkg;

   // byte address of the slice quantum register
   localparam logic [2:0] QUANTUM_ADDR = 3'd0;

endpackage

>>> bench/sched_observer.sv
// observer that predicts every scheduler result and compares it on arrival
module sched_observer
   import rrs_pkg::*;
   import sched_bench_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         busy,
   input  req_item_type req_item,
   input  logic         rsp_valid,
   input  rsp_item_type rsp_item,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic         pready,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   input  logic [31:0]  prdata,
   output int           mismatches,
   output int           outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint unsigned TIME_MAX  = (64'd1 << TIME_BITS) - 1;
   localparam longint unsigned CLOCK_MAX = (64'd1 << CLOCK_BITS) - 1;
   localparam longint unsigned TOTAL_MAX = (64'd1 << TOTAL_BITS) - 1;

   // shadow copy of the scheduler state
   logic [15:0] quantum;
   time_type    burst_tab [MAX_JOBS];
   time_type    left_tab [MAX_JOBS];
   mask_type    done_mask;
   count_type   loaded;
   idx_type     cursor;
   clock_type   sim_clock;
   count_type   finished;
   total_type   wait_sum;
   total_type   done_sum;

   // results predicted for accepted requests, oldest first
   rsp_item_type awaited_results [$];

   task automatic report(input string what);
      if (mismatches < 10) begin
         $display("%0t ns: mismatch: %s", $time, what);
      end
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report($sformatf("%s expected %0h got %0h", name, want, got));
      end
   endtask

   function automatic longint unsigned sat_add(input longint unsigned a,
                                               input longint unsigned b,
                                               input longint unsigned top);
      return (a + b > top) ? top : a + b;
   endfunction

   // apply one request to the shadow state and return its result
   function automatic rsp_item_type schedule_request(input req_item_type r);
      rsp_item_type    res;
      int              slot;
      idx_type         pos;
      bit              found;
      longint unsigned slice_q;
      longint unsigned run;
      longint unsigned wait_ticks;
      res = '0;
      res.status = STATUS_OK;
      found = 1'b0;
      if (r.req_type == REQ_LOAD) begin
         if (loaded >= MAX_JOBS) begin
            res.status = STATUS_FULL;
         end else begin
            pos = idx_type'(loaded);
            burst_tab[pos] = (r.job_burst > TIME_MAX) ? time_type'(TIME_MAX)
                                                      : time_type'(r.job_burst);
            left_tab[pos] = burst_tab[pos];
            done_mask[pos] = 1'b0;
            res.job_id = id_type'(loaded + 1);
            loaded = loaded + 1'b1;
         end
      end else begin
         // rotating search from the cursor over loaded, unfinished jobs
         slice_q = (quantum == '0) ? 1 : quantum;
         for (int k = 0; k < MAX_JOBS; k++) begin
            slot = (int'(cursor) + k) % MAX_JOBS;
            pos = idx_type'(slot);
            if (!found && slot < loaded && !done_mask[pos]) begin
               found = 1'b1;
               run = (left_tab[pos] <= slice_q) ? left_tab[pos] : slice_q;
               left_tab[pos] = time_type'(left_tab[pos] - run);
               sim_clock = clock_type'(sat_add(sim_clock, run, CLOCK_MAX));
               cursor = idx_type'((slot + 1) % MAX_JOBS);
               res.slice_valid = 1'b1;
               res.job_id = id_type'(slot + 1);
               res.slice_length = slice_type'(run);
               if (left_tab[pos] == '0) begin
                  wait_ticks = (sim_clock >= burst_tab[pos]) ?
                               sim_clock - burst_tab[pos] : 0;
                  done_mask[pos] = 1'b1;
                  finished = finished + 1'b1;
                  wait_sum = total_type'(sat_add(wait_sum, wait_ticks, TOTAL_MAX));
                  done_sum = total_type'(sat_add(done_sum, sim_clock, TOTAL_MAX));
                  res.job_done = 1'b1;
                  res.done_time = sim_clock;
                  res.wait_time = clock_type'(wait_ticks);
               end
            end
         end
         if (!found) begin
            res.status = STATUS_NOTHING;
         end
      end
      res.clock_now = sim_clock;
      res.all_finished = (finished == loaded);
      res.sum_wait = wait_sum;
      res.sum_done = done_sum;
      return res;
   endfunction

   // compare results, record requests and register traffic
   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         quantum = 16'd1;
         done_mask = '0;
         loaded = '0;
         cursor = '0;
         sim_clock = '0;
         finished = '0;
         wait_sum = '0;
         done_sum = '0;
         awaited_results.delete();
      end else begin
         if (rsp_valid) begin
            if (awaited_results.size() == 0) begin
               report("result with no request outstanding");
            end else begin
               want = awaited_results.pop_front();
               check_field("slice_valid", 32'(rsp_item.slice_valid), 32'(want.slice_valid));
               check_field("job_id", 32'(rsp_item.job_id), 32'(want.job_id));
               check_field("slice_length", 32'(rsp_item.slice_length),
                           32'(want.slice_length));
               check_field("job_done", 32'(rsp_item.job_done), 32'(want.job_done));
               check_field("done_time", 32'(rsp_item.done_time), 32'(want.done_time));
               check_field("wait_time", 32'(rsp_item.wait_time), 32'(want.wait_time));
               check_field("clock_now", 32'(rsp_item.clock_now), 32'(want.clock_now));
               check_field("all_finished", 32'(rsp_item.all_finished),
                           32'(want.all_finished));
               check_field("sum_wait", 32'(rsp_item.sum_wait), 32'(want.sum_wait));
               check_field("sum_done", 32'(rsp_item.sum_done), 32'(want.sum_done));
               check_field("status", 32'(rsp_item.status), 32'(want.status));
            end
         end
         if (start && !busy) begin
            awaited_results.push_back(schedule_request(req_item));
         end
         if (psel && penable && pready && paddr == QUANTUM_ADDR) begin
            if (pwrite) begin
               quantum = pwdata[15:0];
            end else begin
               check_field("quantum readback", 32'(prdata[15:0]), 32'(quantum));
            end
         end
      end
      outstanding = awaited_results.size();
   end

endmodule

>>> bench/testbench.sv
// stimulus and verdict for the round-robin scheduler regression
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import rrs_pkg::*;
   import sched_bench_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 1000;
   localparam int PHASES       = 8;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_item_type req_item = '0;
   logic         rsp_valid;
   rsp_item_type rsp_item;
   logic         psel = 1'b0;
   logic         penable = 1'b0;
   logic         pwrite = 1'b0;
   logic [2:0]   paddr = '0;
   logic [31:0]  pwdata = '0;
   logic [31:0]  prdata;
   logic         pready;

   int mismatches;
   int outstanding;
   int cycle_count = 0;
   int burst_left = 0;

   round_robin_scheduler_sim_top uut (
      .clock(clock), .reset(reset),
      .start(start), .busy(busy), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_item(rsp_item),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   sched_observer observer (
      .clock(clock), .reset(reset),
      .start(start), .busy(busy), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_item(rsp_item),
      .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
      .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
      .mismatches(mismatches), .outstanding(outstanding)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // run-away guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // present one request at a falling edge and hold it until accepted
   task automatic send_request(input req_item_type r);
      start <= 1'b1;
      req_item <= r;
      while (busy) @(negedge clock);
      @(negedge clock);
   endtask

   task automatic send(input logic kind, input logic [15:0] burst);
      req_item_type r;
      r.req_type = kind;
      r.job_burst = burst;
      send_request(r);
   endtask

   // drop start and wait for every result to come back
   task automatic wait_idle();
      start <= 1'b0;
      @(negedge clock);
      while (outstanding != 0 || busy) @(negedge clock);
   endtask

   // quantum write followed by a readback
   task automatic set_quantum(input logic [15:0] value);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= QUANTUM_ADDR;
      pwdata <= {16'h0, value};
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
   endtask

   // sender works in bursts with random gaps between them
   task automatic pace();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   // burst times: mostly short, with the extremes mixed in
   function automatic logic [15:0] pick_burst();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'($urandom);
         default: return 16'($urandom_range(1, 300));
      endcase
   endfunction

   function automatic logic [15:0] phase_quantum(input int phase);
      case (phase)
         0: return 16'd3;
         1: return 16'd0;
         2: return 16'($urandom_range(2, 20));
         3: return 16'd1;
         4: return 16'($urandom_range(1, 65535));
         5: return 16'($urandom_range(2, 20));
         6: return 16'hFFFF;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // runs dominate so the loaded jobs keep getting served
   function automatic req_item_type random_request();
      req_item_type r;
      r.req_type = ($urandom_range(0, 7) == 0) ? REQ_LOAD : REQ_RUN;
      r.job_burst = (r.req_type == REQ_LOAD) ? pick_burst() : 16'($urandom);
      return r;
   endfunction

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty table: nothing pending, all finished
      send(REQ_RUN, 16'h1234);
      // zero burst, widest burst, short jobs
      send(REQ_LOAD, 16'h0000);
      send(REQ_LOAD, 16'hFFFF);
      send(REQ_LOAD, 16'h0002);
      send(REQ_LOAD, 16'h0001);
      repeat (5) send(REQ_RUN, 16'h0000);

      // zero quantum acts as one tick
      wait_idle();
      set_quantum(16'h0000);
      repeat (3) send(REQ_RUN, 16'hFFFF);

      // widest quantum drains every job, then nothing is left
      wait_idle();
      set_quantum(16'hFFFF);
      repeat (4) send(REQ_RUN, 16'h5A5A);

      // late loads join the rotation
      send(REQ_LOAD, 16'h5555);
      send(REQ_RUN, 16'h0000);
      send(REQ_LOAD, 16'hAAAA);
      send(REQ_RUN, 16'h0000);
      send(REQ_RUN, 16'h0000);

      // random phases, each under its own quantum
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_idle();
         set_quantum(phase_quantum(phase));
         for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
            send_request(random_request());
            pace();
         end
      end

      // overfill the table
      wait_idle();
      set_quantum(16'($urandom_range(1, 65535)));
      repeat (17) send(REQ_LOAD, pick_burst());
      repeat (4) send(REQ_RUN, 16'($urandom));

      wait_idle();
      repeat (8) @(negedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

>>> round_robin_scheduler_sim_top.f
design/rrs_pkg.sv
design/rrs_ram.sv
design/rrs_pick.sv
design/round_robin_scheduler_sim_top.sv
bench/sched_bench_pkg.sv
bench/sched_observer.sv
bench/testbench.sv
